/* design/emp_pkg.sv */
// shared types, constants and field widths for the energy meter post-processor
package emp_pkg;

    // field widths
    localparam int MODE_W = 2;
    localparam int RAW_W  = 24;
    localparam int VAL_W  = 32;
    localparam int PF_W   = 7;
    localparam int EPK_W  = 16;
    localparam int VS_W   = 10;
    localparam int AS_W   = 11;
    localparam int CFGI_W = 2;
    localparam int CFGD_W = 16;
    localparam int RES_W  = 18;
    localparam int VH_W   = 16;
    localparam int CUR_W  = 15;
    localparam int ADD_W  = 17;

    // voltage history
    localparam int HISTORY_DEPTH = 8;
    localparam int VSUM_W        = VH_W + $clog2(HISTORY_DEPTH);

    // shared divider
    localparam int DIV_W = 32;
    localparam int DSR_W = 24;
    localparam int CNT_W = $clog2(DIV_W + 1);

    // dividend widths per operation
    localparam int PF_BITS = 31;
    localparam int E_BITS  = RES_W;
    localparam int R_BITS  = RAW_W;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_ENERGY = 2'd0;
    localparam logic [MODE_W-1:0] MODE_VOLT   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CURR   = 2'd2;

    // register indexes
    localparam logic [CFGI_W-1:0] CFG_EPK = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_VS  = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_AS  = 2'd2;

    // register reset values
    localparam logic [EPK_W-1:0] EPK_RESET = 16'd1000;
    localparam logic [VS_W-1:0]  VS_RESET  = 10'd52;
    localparam logic [AS_W-1:0]  AS_RESET  = 11'd400;

    // thresholds and limits
    localparam logic [PF_W-1:0]  PF_FULL  = 7'd100;
    localparam logic [RAW_W-1:0] APP_MIN  = 24'd600;
    localparam logic [CUR_W-1:0] CUR_MIN  = 15'd100;
    localparam logic [RAW_W-1:0] ACT_MIN  = 24'd300;
    localparam logic [RAW_W-1:0] ACT_MAX  = 24'd100000;
    localparam logic [VAL_W-1:0] VAVG_MIN = 32'd2000;
    localparam logic [VH_W-1:0]  VOLT_INIT = 16'd22000;
    localparam logic [VH_W-1:0]  VOLT_SAT  = 16'hFFFF;
    localparam logic [CUR_W-1:0] CUR_SAT   = 15'h7FFF;
    localparam logic [VSUM_W-1:0] VSUM_INIT = VSUM_W'(22000 * HISTORY_DEPTH);

    // divider request and response
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
        logic [CNT_W-1:0] nbits;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DSR_W-1:0] remainder;
    } t_div_rsp;

endpackage

/* design/emp_div.sv */
// shared restoring divider, one quotient bit per cycle
module emp_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  emp_pkg::t_div_req i_req,
    output emp_pkg::t_div_rsp o_rsp
);
    import emp_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DSR_W-1:0] r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [DSR_W-1:0] r_dsr;

    logic [DSR_W:0]   shifted;
    logic [DSR_W+1:0] trial;
    logic             neg;
    logic [DSR_W-1:0] n_rem;

    // one trial subtraction per step
    always_comb begin
        shifted = {r_rem, r_quo[DIV_W-1]};
        trial   = {1'b0, shifted} - {2'b00, r_dsr};
        neg     = trial[DSR_W+1];
        n_rem   = neg ? shifted[DSR_W-1:0] : trial[DSR_W-1:0];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.nbits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dsr <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DIV_W-2:0], ~neg};
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

    // checks
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");

    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("divider busy with zero count");

endmodule

/* design/emp_vhist.sv */
// voltage history shift line with running sum
module emp_vhist (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [emp_pkg::VH_W-1:0]     i_data,
    output logic [emp_pkg::VSUM_W-1:0]   o_sum
);
    import emp_pkg::*;

    logic [VH_W-1:0]   r_hist [HISTORY_DEPTH];
    logic [VSUM_W-1:0] r_sum;
    logic [VSUM_W-1:0] n_sum;

    // newest enters, oldest leaves the sum
    assign n_sum = r_sum + VSUM_W'(i_data) - VSUM_W'(r_hist[HISTORY_DEPTH-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_hist[i] <= VOLT_INIT;
            end
            r_sum <= VSUM_INIT;
        end else if (i_push) begin
            for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
                r_hist[i] <= r_hist[i-1];
            end
            r_hist[0] <= i_data;
            r_sum     <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

/* design/energy_meter_postprocessor_top.sv */
// top level: sequencer, state and registers of the energy meter post-processor
//
// One item is handled at a time; the time per item is set by a single shared
// restoring divider that yields one quotient bit per cycle. An energy item uses
// the divider twice when the power factor needs a division (31 bits for the factor,
// 18 bits for the kWh step) and once when it does not; a voltage item divides for
// scaling, then takes a shift for the average over the history; a current item
// divides once; a zero scale or the unused mode skips the divider. A finished result
// sits in the output register, so the next item is taken while it waits. The config
// port is always ready; registers should only be written with the block idle.
module energy_meter_postprocessor_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input items
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [emp_pkg::MODE_W-1:0]  i_mode,
    input  logic [emp_pkg::RAW_W-1:0]   i_active_energy,
    input  logic [emp_pkg::RAW_W-1:0]   i_apparent_energy,
    input  logic [emp_pkg::RAW_W-1:0]   i_rms_reading,
    // results
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [emp_pkg::VAL_W-1:0]   o_value,
    output logic [emp_pkg::PF_W-1:0]    o_power_factor,
    // configuration writes
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [emp_pkg::CFGI_W-1:0]  i_cfg_index,
    input  logic [emp_pkg::CFGD_W-1:0]  i_cfg_data
);
    import emp_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_DISPATCH = 9'b000000010,
        S_PF_DIV   = 9'b000000100,
        S_E_START  = 9'b000001000,
        S_E_DIV    = 9'b000010000,
        S_V_DIV    = 9'b000100000,
        S_V_AVG    = 9'b001000000,
        S_C_DIV    = 9'b010000000,
        S_OUT      = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [MODE_W-1:0] r_mode, n_mode;
    logic [RAW_W-1:0]  r_act, n_act;
    logic [RAW_W-1:0]  r_app, n_app;
    logic [RAW_W-1:0]  r_rms, n_rms;

    logic [EPK_W-1:0]  r_epk;
    logic [VS_W-1:0]   r_vs;
    logic [AS_W-1:0]   r_as;

    logic [RES_W-1:0]  r_residual, n_residual;
    logic [VAL_W-1:0]  r_kwh, n_kwh;
    logic [CUR_W-1:0]  r_last_cur, n_last_cur;
    logic [PF_W-1:0]   r_pf, n_pf;
    logic [VAL_W-1:0]  r_res, n_res;

    logic              r_out_valid, n_out_valid;
    logic [VAL_W-1:0]  r_out_value, n_out_value;
    logic [PF_W-1:0]   r_out_pf, n_out_pf;

    t_div_req          div_req;
    t_div_rsp          div_rsp;
    logic              v_push;
    logic [VH_W-1:0]   v_data;
    logic [VSUM_W-1:0] v_sum;
    logic [VSUM_W-1:0] v_avg;

    logic [PF_BITS-1:0] pf_prod;
    logic [ADD_W-1:0]   e_add;
    logic [RES_W-1:0]   e_sum;
    logic [VAL_W-1:0]   kwh_next;
    logic [CUR_W-1:0]   cur_sat;

    emp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    emp_vhist u_vhist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (v_push),
        .i_data  (v_data),
        .o_sum   (v_sum)
    );

    // helper arithmetic
    always_comb begin
        pf_prod = (PF_BITS'(r_act) << 6) + (PF_BITS'(r_act) << 5) + (PF_BITS'(r_act) << 2);
        e_add   = ((r_act < ACT_MIN) || (r_act > ACT_MAX)) ? '0 : r_act[ADD_W-1:0];
        e_sum   = r_residual + RES_W'(e_add);
        kwh_next = r_kwh + div_rsp.quotient;
        cur_sat = (div_rsp.quotient[DIV_W-1:CUR_W] != '0) ? CUR_SAT
                                                        : div_rsp.quotient[CUR_W-1:0];
        v_data  = (div_rsp.quotient[DIV_W-1:VH_W] != '0) ? VOLT_SAT
                                                       : div_rsp.quotient[VH_W-1:0];
        // history depth is a power of two, so the average is a shift
        v_avg   = v_sum / VSUM_W'(HISTORY_DEPTH);
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_act       = r_act;
        n_app       = r_app;
        n_rms       = r_rms;
        n_residual  = r_residual;
        n_kwh       = r_kwh;
        n_last_cur  = r_last_cur;
        n_pf        = r_pf;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        n_out_pf    = r_out_pf;
        div_req     = '0;
        v_push      = 1'b0;

        // result taken downstream
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode  = i_mode;
                    n_act   = i_active_energy;
                    n_app   = i_apparent_energy;
                    n_rms   = i_rms_reading;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (r_mode)
                    MODE_ENERGY: begin
                        if (r_epk == '0) begin
                            n_res   = '0;
                            n_state = S_OUT;
                        end else if ((r_app < APP_MIN) || (r_last_cur < CUR_MIN)) begin
                            n_pf    = PF_FULL;
                            n_state = S_E_START;
                        end else begin
                            div_req.start    = 1'b1;
                            div_req.dividend = {pf_prod, {(DIV_W-PF_BITS){1'b0}}};
                            div_req.divisor  = r_app;
                            div_req.nbits    = CNT_W'(PF_BITS);
                            n_state          = S_PF_DIV;
                        end
                    end
                    MODE_VOLT: begin
                        if (r_vs == '0) begin
                            n_res   = '0;
                            n_state = S_OUT;
                        end else begin
                            div_req.start    = 1'b1;
                            div_req.dividend = {r_rms, {(DIV_W-R_BITS){1'b0}}};
                            div_req.divisor  = DSR_W'(r_vs);
                            div_req.nbits    = CNT_W'(R_BITS);
                            n_state          = S_V_DIV;
                        end
                    end
                    MODE_CURR: begin
                        if (r_as == '0) begin
                            n_res   = '0;
                            n_state = S_OUT;
                        end else begin
                            div_req.start    = 1'b1;
                            div_req.dividend = {r_rms, {(DIV_W-R_BITS){1'b0}}};
                            div_req.divisor  = DSR_W'(r_as);
                            div_req.nbits    = CNT_W'(R_BITS);
                            n_state          = S_C_DIV;
                        end
                    end
                    default: begin
                        n_res   = '0;
                        n_state = S_OUT;
                    end
                endcase
            end
            S_PF_DIV: begin
                if (div_rsp.done) begin
                    n_pf    = (div_rsp.quotient >= VAL_W'(PF_FULL)) ? PF_FULL
                                                                  : div_rsp.quotient[PF_W-1:0];
                    n_state = S_E_START;
                end
            end
            S_E_START: begin
                div_req.start    = 1'b1;
                div_req.dividend = {e_sum, {(DIV_W-E_BITS){1'b0}}};
                div_req.divisor  = DSR_W'(r_epk);
                div_req.nbits    = CNT_W'(E_BITS);
                n_state          = S_E_DIV;
            end
            S_E_DIV: begin
                if (div_rsp.done) begin
                    n_kwh      = kwh_next;
                    n_residual = div_rsp.remainder[RES_W-1:0];
                    n_res      = kwh_next;
                    n_state    = S_OUT;
                end
            end
            S_V_DIV: begin
                if (div_rsp.done) begin
                    v_push  = 1'b1;
                    n_state = S_V_AVG;
                end
            end
            S_V_AVG: begin
                n_res   = (VAL_W'(v_avg) < VAVG_MIN) ? '0 : VAL_W'(v_avg);
                n_state = S_OUT;
            end
            S_C_DIV: begin
                if (div_rsp.done) begin
                    n_last_cur = cur_sat;
                    n_res      = (cur_sat < CUR_MIN) ? '0 : VAL_W'(cur_sat);
                    n_state    = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_res;
                    n_out_pf    = r_pf;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_residual  <= '0;
            r_kwh       <= '0;
            r_last_cur  <= '0;
            r_pf        <= PF_FULL;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_residual  <= n_residual;
            r_kwh       <= n_kwh;
            r_last_cur  <= n_last_cur;
            r_pf        <= n_pf;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mode      <= n_mode;
        r_act       <= n_act;
        r_app       <= n_app;
        r_rms       <= n_rms;
        r_res       <= n_res;
        r_out_value <= n_out_value;
        r_out_pf    <= n_out_pf;
    end

    // configuration registers, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epk <= EPK_RESET;
            r_vs  <= VS_RESET;
            r_as  <= AS_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_EPK: r_epk <= i_cfg_data;
                CFG_VS:  r_vs  <= i_cfg_data[VS_W-1:0];
                CFG_AS:  r_as  <= i_cfg_data[AS_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_value        = r_out_value;
    assign o_power_factor = r_out_pf;

    // checks
    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_PF_DIV || r_state == S_E_DIV ||
                          r_state == S_V_DIV || r_state == S_C_DIV))
        else $error("divider result arrived outside a wait state");

    a_pf_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_power_factor <= PF_FULL))
        else $error("power factor above full scale");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && (!r_out_valid || i_out_ready))
        |=> (r_state == S_IDLE && o_out_valid))
        else $error("result not loaded into free output register");

endmodule
